@@ hw/rtl/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// sal_pkg
// shared types and constants of the set-associative lru tag store
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int DEF_MAX_SETS = 1024;
    localparam int DEF_MAX_WAYS = 8;

    localparam int SET_IDX_W = 16;
    localparam int CFG_W     = 4;

    localparam logic [1:0] ACT_LOOKUP     = 2'd0;
    localparam logic [1:0] ACT_ACCESS     = 2'd1;
    localparam logic [1:0] ACT_INVALIDATE = 2'd2;

    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_SET_LOG2    = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd6;
    localparam logic [CFG_W-1:0] RST_SET_LOG2    = 4'd6;
    localparam logic [CFG_W-1:0] RST_WAYS        = 4'd8;

    typedef struct packed {
        logic [1:0]           action;
        logic [31:0]          block;
        logic [SET_IDX_W-1:0] set_idx;
        logic [31:0]          stamp;
        logic [CFG_W-1:0]     off;
    } item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic valid;
    } queue_ctrl_t;

endpackage

@@ hw/rtl/sal_front.sv @@
// ----------------------------------------------------------------------------
// sal_front
// accepts words, forms the block number and reduces it to a set index
// ----------------------------------------------------------------------------
module sal_front
    import sal_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [31:0]          address,
    input  logic [31:0]          access_time,
    input  logic [CFG_W-1:0]     cfg_offset,
    input  logic [CFG_W-1:0]     cfg_set_log2,
    input  back_status_t         back_status,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    localparam bit          POW2     = (MAX_SETS & (MAX_SETS - 1)) == 0;
    localparam logic [32:0] MOD_BASE = 33'(MAX_SETS);
    localparam logic [15:0] SET_MASK = 16'(MAX_SETS - 1);

    logic                 hold_valid_reg;
    item_t                item_reg;
    logic [4:0]           step_reg;
    logic                 accept;
    logic [31:0]          block;
    logic [4:0]           s_cap;
    logic [16:0]          idx_mask;
    logic [15:0]          idx;
    logic [3:0]           k;
    logic [32:0]          cmp;
    logic [15:0]          rem_next;

    assign q_push   = hold_valid_reg && (step_reg == 5'd0) && !q_full;
    assign in_stall = back_status.clearing || (hold_valid_reg && !q_push);
    assign accept   = in_valid && !in_stall;
    assign q_item   = item_reg;

    always_comb
    begin
        block    = address >> cfg_offset;
        s_cap    = (cfg_set_log2 > 4'd15) ? 5'd16 : {1'b0, cfg_set_log2};
        idx_mask = (17'd1 << s_cap) - 17'd1;
        idx      = block[15:0] & idx_mask[15:0];
        k        = 4'(step_reg - 5'd1);
        cmp      = MOD_BASE << k;
        rem_next = item_reg.set_idx;
        if ({17'd0, item_reg.set_idx} >= cmp)
        begin
            rem_next = item_reg.set_idx - cmp[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            step_reg       <= 5'd0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
            step_reg       <= POW2 ? 5'd0 : 5'd16;
        end
        else
        begin
            if (q_push)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (step_reg != 5'd0)
            begin
                step_reg <= step_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action  <= action;
            item_reg.block   <= block;
            item_reg.stamp   <= access_time;
            item_reg.off     <= cfg_offset;
            item_reg.set_idx <= POW2 ? (idx & SET_MASK) : idx;
        end
        else if (step_reg != 5'd0)
        begin
            item_reg.set_idx <= rem_next;
        end
    end

endmodule

@@ hw/rtl/sal_queue.sv @@
// ----------------------------------------------------------------------------
// sal_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module sal_queue
    import sal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       push_item,
    output logic        full,
    output queue_ctrl_t ctrl_out,
    input  logic        pop,
    output item_t       head
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full           = count_reg == 2'd2;
    assign ctrl_out.valid = count_reg != 2'd0;
    assign head           = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/sal_back.sv @@
// ----------------------------------------------------------------------------
// sal_back
// set memories, hit search, lru victim choice and write-back
// ----------------------------------------------------------------------------
module sal_back
    import sal_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  queue_ctrl_t      q_ctrl,
    input  item_t            q_head,
    output logic             q_pop,
    input  logic [CFG_W-1:0] cfg_ways,
    output back_status_t     status,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output logic             evicted,
    output logic [31:0]      evicted_address
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W = MAX_WAYS * 32;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [ROW_W-1:0]    tag_mem   [MAX_SETS];
    logic [ROW_W-1:0]    stamp_mem [MAX_SETS];
    logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];

    logic [1:0]          state_reg, state_next;
    logic [SET_W-1:0]    clr_reg;
    item_t               cur_reg;
    logic [ROW_W-1:0]    rd_tag_reg, rd_stamp_reg;
    logic [MAX_WAYS-1:0] rd_valid_reg;
    logic                out_valid_reg, hit_reg, evicted_reg;
    logic [31:0]         ev_addr_reg;

    logic                rd_en;
    logic                out_free, finish;
    logic                wr_en;
    logic [SET_W-1:0]    wr_addr;
    logic [ROW_W-1:0]    new_tag, new_stamp;
    logic [MAX_WAYS-1:0] new_valid;

    logic                f_hit, found_old, found_free, do_evict;
    logic [WAY_W-1:0]    hit_way, old_way, free_way, slot;
    logic [31:0]         oldest;
    logic [5:0]          cnt, eff;
    logic [31:0]         ev_addr;

    assign status.clearing = state_reg == ST_CLEAR;
    assign out_free        = !out_valid_reg || !out_stall;
    assign rd_en           = (state_reg == ST_IDLE) && q_ctrl.valid;
    assign q_pop           = rd_en;
    assign finish          = (state_reg == ST_EVAL) && out_free;
    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign evicted         = evicted_reg;
    assign evicted_address = ev_addr_reg;

    always_comb
    begin
        f_hit      = 1'b0;
        found_old  = 1'b0;
        found_free = 1'b0;
        hit_way    = '0;
        old_way    = '0;
        free_way   = '0;
        oldest     = '0;
        cnt        = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (rd_valid_reg[w])
            begin
                cnt = cnt + 6'd1;
                if (!f_hit && rd_tag_reg[w*32 +: 32] == cur_reg.block)
                begin
                    f_hit   = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!found_old || rd_stamp_reg[w*32 +: 32] < oldest)
                begin
                    found_old = 1'b1;
                    oldest    = rd_stamp_reg[w*32 +: 32];
                    old_way   = WAY_W'(w);
                end
            end
            else if (!found_free)
            begin
                found_free = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        eff = {2'b00, cfg_ways};
        if (eff == 6'd0)
        begin
            eff = 6'd1;
        end
        if (eff > 6'(MAX_WAYS))
        begin
            eff = 6'(MAX_WAYS);
        end

        do_evict = (cur_reg.action == ACT_ACCESS) && !f_hit && (cnt >= eff);
        slot     = do_evict ? old_way : free_way;
        ev_addr  = do_evict ? (rd_tag_reg[slot*32 +: 32] << cur_reg.off) : 32'd0;

        new_tag   = rd_tag_reg;
        new_stamp = rd_stamp_reg;
        new_valid = rd_valid_reg;
        case (cur_reg.action)
            ACT_ACCESS:
            begin
                if (f_hit)
                begin
                    new_stamp[hit_way*32 +: 32] = cur_reg.stamp;
                end
                else
                begin
                    new_valid[slot]          = 1'b1;
                    new_tag[slot*32 +: 32]   = cur_reg.block;
                    new_stamp[slot*32 +: 32] = cur_reg.stamp;
                end
            end
            ACT_INVALIDATE:
            begin
                if (f_hit)
                begin
                    new_valid[hit_way] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        wr_en   = status.clearing || finish;
        wr_addr = status.clearing ? clr_reg : cur_reg.set_idx[SET_W-1:0];
        if (status.clearing)
        begin
            new_valid = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (status.clearing)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hit_reg     <= f_hit;
            evicted_reg <= do_evict;
            ev_addr_reg <= ev_addr;
        end
        if (rd_en)
        begin
            cur_reg      <= q_head;
            rd_tag_reg   <= tag_mem[q_head.set_idx[SET_W-1:0]];
            rd_stamp_reg <= stamp_mem[q_head.set_idx[SET_W-1:0]];
            rd_valid_reg <= valid_mem[q_head.set_idx[SET_W-1:0]];
        end
        if (wr_en)
        begin
            valid_mem[wr_addr] <= new_valid;
            if (!status.clearing)
            begin
                tag_mem[wr_addr]   <= new_tag;
                stamp_mem[wr_addr] <= new_stamp;
            end
        end
    end

endmodule

@@ hw/rtl/set_assoc_lru_tag_store.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store
// tag store of a set-associative cache with lru replacement
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with action, address and access_time;
// a word is taken on a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with hit, evicted, evicted_address;
// exactly one result word per input word, in order.
// the front forms the block number and set index (masked directly when MAX_SETS
// is a power of two, otherwise followed by a restoring reduction modulo MAX_SETS)
// and hands the word through a two-entry queue to the back.
// the back reads one set row from the set memories, then evaluates and
// writes the row back, using the set memories single-port read-then-write;
// it takes no new word until that write is done, and the write waits while
// a stalled result is held.
// after reset the back clears the valid row memory, one set per cycle,
// until every set is cleared; in_stall stays high meanwhile. configuration writes
// are taken at any time.
// a stalled result holds; the queue lets the front keep taking words until it fills.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store
    import sal_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [31:0]      address,
    input  logic [31:0]      access_time,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output logic             evicted,
    output logic [31:0]      evicted_address
);

    logic [CFG_W-1:0] offset_reg, set_log2_reg, ways_reg;
    back_status_t     back_status;
    queue_ctrl_t      q_ctrl;
    item_t            push_item, head_item;
    logic             q_push, q_full, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= RST_OFFSET_BITS;
            set_log2_reg <= RST_SET_LOG2;
            ways_reg     <= RST_WAYS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_reg   <= cfg_data;
                CFG_SET_LOG2:    set_log2_reg <= cfg_data;
                CFG_WAYS:        ways_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sal_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .address      (address),
        .access_time  (access_time),
        .cfg_offset   (offset_reg),
        .cfg_set_log2 (set_log2_reg),
        .back_status  (back_status),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    sal_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .ctrl_out  (q_ctrl),
        .pop       (q_pop),
        .head      (head_item)
    );

    sal_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_ctrl          (q_ctrl),
        .q_head          (head_item),
        .q_pop           (q_pop),
        .cfg_ways        (ways_reg),
        .status          (back_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .evicted         (evicted),
        .evicted_address (evicted_address)
    );

endmodule

@@ hw/rtl/sal_checker.sv @@
// ----------------------------------------------------------------------------
// sal_checker
// port-level checks of the tag store, bound to the top level
// ----------------------------------------------------------------------------
module sal_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic        evicted,
    input logic [31:0] evicted_address
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(evicted_address) && $stable(hit))
        else $error("stalled result word changed");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit)
        else $error("eviction reported on a hit");

    a_evict_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_address == 32'd0)
        else $error("evicted address without eviction");

endmodule

bind set_assoc_lru_tag_store sal_checker u_sal_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .evicted         (evicted),
    .evicted_address (evicted_address)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the set-associative lru tag store against a behavioral tag store:
// directed lookup, access, invalidate and eviction words, then random
// traffic on a small pool of blocks under several cache geometries
// ----------------------------------------------------------------------------
module tb;
    import sal_pkg::*;

    localparam int NSETS = DEF_MAX_SETS;
    localparam int NWAYS = DEF_MAX_WAYS;
    localparam int LIMIT = 400000;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic        hit;
        logic        evicted;
        logic [31:0] evicted_address;
    } lookup_res_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       action;
    logic [31:0]      address;
    logic [31:0]      access_time;
    logic             out_valid;
    logic             out_stall;
    logic             hit;
    logic             evicted;
    logic [31:0]      evicted_address;

    logic [3:0]  m_off;
    logic [3:0]  m_slog2;
    logic [3:0]  m_ways;
    logic        m_valid [NSETS][NWAYS];
    logic [31:0] m_tag   [NSETS][NWAYS];
    logic [31:0] m_stamp [NSETS][NWAYS];

    lookup_res_t expected_q[$];
    int          errors;
    int          results_seen;
    int          cycles;
    int          hits_seen;
    int          evicts_seen;
    bit          idle_in;
    bit          idle_out;
    bit          hold_out;

    set_assoc_lru_tag_store i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // predicted tag store update for one word
    function automatic lookup_res_t predict_lookup(logic [1:0] act, logic [31:0] addr,
                                                   logic [31:0] ts);
        lookup_res_t r;
        logic [31:0] blk;
        int          s;
        int          lg;
        int          cnt;
        int          hw;
        int          slot;
        int          ew;
        bit          found;
        logic [31:0] oldest;
        r.hit = 1'b0;
        r.evicted = 1'b0;
        r.evicted_address = '0;
        blk = addr >> m_off;
        lg = (m_slog2 > 16) ? 16 : m_slog2;
        s = (blk & ((32'd1 << lg) - 1)) % NSETS;
        cnt = 0;
        hw = 0;
        for (int w = 0; w < NWAYS; w++)
        begin
            if (m_valid[s][w])
            begin
                cnt++;
                if (!r.hit && m_tag[s][w] == blk)
                begin
                    r.hit = 1'b1;
                    hw = w;
                end
            end
        end
        ew = (m_ways == 0) ? 1 : ((m_ways > NWAYS) ? NWAYS : m_ways);
        if (act == ACT_ACCESS)
        begin
            if (r.hit)
                m_stamp[s][hw] = ts;
            else
            begin
                slot = 0;
                if (cnt >= ew)
                begin
                    found = 0;
                    oldest = '0;
                    for (int w = 0; w < NWAYS; w++)
                    begin
                        if (m_valid[s][w] && (!found || m_stamp[s][w] < oldest))
                        begin
                            found = 1;
                            oldest = m_stamp[s][w];
                            slot = w;
                        end
                    end
                    r.evicted = 1'b1;
                    r.evicted_address = 32'(64'(m_tag[s][slot]) << m_off);
                end
                else
                begin
                    for (int w = NWAYS - 1; w >= 0; w--)
                        if (!m_valid[s][w])
                            slot = w;
                end
                m_valid[s][slot] = 1'b1;
                m_tag[s][slot] = blk;
                m_stamp[s][slot] = ts;
            end
        end
        else if (act == ACT_INVALIDATE && r.hit)
            m_valid[s][hw] = 1'b0;
        return r;
    endfunction

    task automatic send_word(logic [1:0] act, logic [31:0] addr, logic [31:0] ts);
        while (idle_in && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        access_time <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_lookup(act, addr, ts));
    endtask

    // result checker
    always @(posedge clk)
    begin
        lookup_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                hits_seen += hit;
                evicts_seen += evicted;
                if (hit !== e.hit)
                begin
                    $error("hit exp %0h got %0h", e.hit, hit);
                    errors++;
                end
                if (evicted !== e.evicted)
                begin
                    $error("evicted exp %0h got %0h", e.evicted, evicted);
                    errors++;
                end
                if (evicted_address !== e.evicted_address)
                begin
                    $error("evicted_address exp %0h got %0h", e.evicted_address,
                           evicted_address);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_out)
            out_stall <= 1'b1;
        else
            out_stall <= idle_out && ($urandom_range(99) < 38);
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_OFFSET_BITS) m_off = val;
        else if (idx == CFG_SET_LOG2) m_slog2 = val;
        else if (idx == CFG_WAYS) m_ways = val;
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [3:0] off, logic [3:0] sl, logic [3:0] wy);
        drain();
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_SET_LOG2, sl);
        write_reg(CFG_WAYS, wy);
    endtask

    task automatic test_directed();
        send_word(ACT_LOOKUP, 32'h0000_0000, '0);
        send_word(ACT_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(ACT_LOOKUP, 32'h0000_003F, '0);
        send_word(ACT_ACCESS, 32'hFFFF_FFFF, 32'h0);
        send_word(ACT_SPARE, 32'hFFFF_FFFF, '1);
        send_word(ACT_INVALIDATE, 32'hFFFF_FFFF, '0);
        send_word(ACT_INVALIDATE, 32'hFFFF_FFFF, '0);
        // fill one set past its ways, ties at equal stamps
        for (int i = 0; i < 10; i++)
            send_word(ACT_ACCESS, 32'(i) << 12, (i < 4) ? 32'd5 : 32'(i));
        send_word(ACT_ACCESS, 32'h0000_3000, 32'd100);
        send_word(ACT_ACCESS, 32'h0001_0000, 32'd1);
        send_word(ACT_LOOKUP, 32'h0000_0000, '0);
    endtask

    task automatic test_shrink_ways();
        set_geometry(4'd0, 4'd0, 4'd0);
        for (int i = 0; i < 6; i++)
            send_word(ACT_ACCESS, 32'(i), 32'($urandom));
        set_geometry(4'd15, 4'd15, 4'd15);
        for (int i = 0; i < 12; i++)
            send_word(ACT_ACCESS, 32'($urandom_range(3)) << 15, 32'($urandom));
    endtask

    task automatic test_random(int n, int pool);
        logic [31:0] addrs[];
        logic [1:0]  act;
        int          r;
        addrs = new[pool];
        for (int i = 0; i < pool; i++)
            addrs[i] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            act = (r < 55) ? ACT_ACCESS : (r < 75) ? ACT_LOOKUP
                : (r < 95) ? ACT_INVALIDATE : ACT_SPARE;
            if ($urandom_range(9) == 0)
                send_word(act, $urandom, $urandom);
            else
                send_word(act, addrs[$urandom_range(pool - 1)] ^ $urandom_range(3),
                          $urandom_range(9) == 0 ? $urandom_range(3) : $urandom);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (200) @(posedge clk);
                hold_out = 1'b0;
            end
            test_random(40, 16);
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = '0;
        address = '0;
        access_time = '0;
        out_stall = 1'b0;
        idle_in = 0;
        idle_out = 0;
        hold_out = 0;
        errors = 0;
        results_seen = 0;
        hits_seen = 0;
        evicts_seen = 0;
        cycles = 0;
        m_off = RST_OFFSET_BITS;
        m_slog2 = RST_SET_LOG2;
        m_ways = RST_WAYS;
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++)
            begin
                m_valid[s][w] = 1'b0;
                m_tag[s][w] = '0;
                m_stamp[s][w] = '0;
            end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200, 24);
        idle_in = 1;
        idle_out = 1;
        test_shrink_ways();
        set_geometry(4'd2, 4'd1, 4'd3);
        test_random(300, 20);
        test_backpressure();
        set_geometry(4'd12, 4'd10, 4'd8);
        test_random(200, 64);
        set_geometry(4'd5, 4'd2, 4'd1);
        test_random(250, 12);
        set_geometry(4'd0, 4'd0, 4'd2);
        test_random(200, 8);
        drain();
        $display("covered %0d result words: %0d hits, %0d evictions", results_seen,
                 hits_seen, evicts_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/sal_pkg.sv
hw/rtl/sal_front.sv
hw/rtl/sal_queue.sv
hw/rtl/sal_back.sv
hw/rtl/set_assoc_lru_tag_store.sv
hw/rtl/sal_checker.sv
tb/tb.sv
